// File: rtl/coalescing_region_allocator_defines.svh
// Assertion macros used by the region allocator engine RTL.
`ifndef COALESCING_REGION_ALLOCATOR_DEFINES_SVH
`define COALESCING_REGION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CRA_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define CRA_ASSERT_NXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: rtl/cra_pkg.sv
// Types, constants and codes of the coalescing region allocator.
package cra_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int OFF_W         = 26;
  localparam int HANDLE_W      = 8;
  localparam int MERGE_SLACK   = 2 * 4096;
  localparam logic [OFF_W-1:0] CAP_RESET = OFF_W'(20971520);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REGION_FULL = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_ZERO_SIZE  = 2'd3
  } status_t;

  typedef struct packed {
    logic                func;
    logic [OFF_W-1:0]    request_size;
    logic [HANDLE_W-1:0] handle;
  } in_word_t;

  typedef struct packed {
    status_t             status;
    logic [OFF_W-1:0]    block_offset;
    logic [HANDLE_W-1:0] new_handle;
    logic                entry_moved;
    logic [HANDLE_W-1:0] moved_from;
  } out_word_t;

  // One table entry: span start and length.
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] size;
  } span_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_A_DEC,
    S_RM_RD,
    S_RM_WR,
    S_INS_RD,
    S_INS_WR,
    S_F_RD0,
    S_F_RD1,
    S_R_CHK,
    S_R_NXT,
    S_R_END,
    S_TRIM,
    S_DONE
  } state_t;

endpackage

// File: rtl/cra_ram.sv
// Single-port synchronous RAM with registered read data.
module cra_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 52
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on we, else read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/cra_engine.sv
// Allocator sequencer: keeps the live table and scans, shifts and merges the free table.
`include "coalescing_region_allocator_defines.svh"

module cra_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cra_pkg::OFF_W-1:0]       cap,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cra_pkg::in_word_t               in_data,
  output logic                            res_valid,
  output cra_pkg::out_word_t              res_data,
  input  logic                            slot_free
);

  localparam int W  = cra_pkg::OFF_W;
  localparam int CW = cra_pkg::CNT_W;
  localparam int IW = cra_pkg::IDX_W;

  cra_pkg::state_t    st, st_next, ret, ret_next;
  logic [W-1:0]       size_r, size_r_next, top, top_next;
  logic [cra_pkg::HANDLE_W-1:0] h_r, h_r_next;
  logic [CW-1:0]      lc, lc_next, fc, fc_next, idx, idx_next, j, j_next, t_i, t_i_next;
  cra_pkg::span_t     t, t_next, prev, prev_next, cur, cur_next, sp, sp_next;
  logic               found, found_next;
  cra_pkg::out_word_t res, res_next;

  logic [IW-1:0]      l_addr, f_addr;
  logic               l_we, f_we;
  cra_pkg::span_t     l_wdata, l_rdata, f_wdata, f_rdata;

  cra_ram #(.DEPTH(cra_pkg::TABLE_ENTRIES), .WIDTH($bits(cra_pkg::span_t))) u_live (
    .clk(clk), .addr(l_addr), .we(l_we), .wdata(l_wdata), .rdata(l_rdata)
  );

  cra_ram #(.DEPTH(cra_pkg::TABLE_ENTRIES), .WIDTH($bits(cra_pkg::span_t))) u_free (
    .clk(clk), .addr(f_addr), .we(f_we), .wdata(f_wdata), .rdata(f_rdata)
  );

  assign in_stall  = (st != cra_pkg::S_IDLE);
  assign res_valid = (st == cra_pkg::S_DONE);
  assign res_data  = res;

  // Hold state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= cra_pkg::S_IDLE;
      ret <= cra_pkg::S_DONE;
      lc  <= '0;
      fc  <= '0;
      top <= '0;
    end else begin
      st  <= st_next;
      ret <= ret_next;
      lc  <= lc_next;
      fc  <= fc_next;
      top <= top_next;
    end
  end

  // Hold working payload.
  always_ff @(posedge clk) begin
    size_r <= size_r_next;
    h_r    <= h_r_next;
    idx    <= idx_next;
    j      <= j_next;
    t_i    <= t_i_next;
    t      <= t_next;
    prev   <= prev_next;
    cur    <= cur_next;
    sp     <= sp_next;
    found  <= found_next;
    res    <= res_next;
  end

  // Next state, table accesses and result.
  always_comb begin
    logic [W:0]    endv;
    logic [W:0]    f_end;
    logic [W:0]    p_end;
    logic          consume;
    logic [W-1:0]  off, used, news, ps;
    logic [CW-1:0] newfc, last;
    logic [CW:0]   total;

    st_next     = st;
    ret_next    = ret;
    lc_next     = lc;
    fc_next     = fc;
    top_next    = top;
    size_r_next = size_r;
    h_r_next    = h_r;
    idx_next    = idx;
    j_next      = j;
    t_i_next    = t_i;
    t_next      = t;
    prev_next   = prev;
    cur_next    = cur;
    sp_next     = sp;
    found_next  = found;
    res_next    = res;
    l_addr      = '0;
    l_we        = 1'b0;
    l_wdata     = '0;
    f_addr      = idx[IW-1:0];
    f_we        = 1'b0;
    f_wdata     = '0;

    endv    = {1'b0, sp.off} + {1'b0, sp.size};
    f_end   = {1'b0, f_rdata.off} + {1'b0, f_rdata.size};
    p_end   = {1'b0, prev.off} + {1'b0, prev.size};
    consume = found && (({1'b0, size_r} + (W+1)'(cra_pkg::MERGE_SLACK)) >= {1'b0, cur.size});
    off     = found ? cur.off : top;
    used    = consume ? cur.size : size_r;
    newfc   = fc - CW'(consume);
    total   = {1'b0, lc} + {1'b0, newfc} + (CW+1)'(1);
    news    = f_rdata.size + sp.size;
    ps      = prev.size + news;
    last    = lc - CW'(1);

    unique case (st)
      cra_pkg::S_IDLE: begin
        if (in_valid) begin
          res_next   = '0;
          found_next = 1'b0;
          if (in_data.func == cra_pkg::FUNC_ALLOC) begin
            size_r_next = in_data.request_size;
            if (in_data.request_size == '0) begin
              res_next.status = cra_pkg::ST_ZERO_SIZE;
              st_next = cra_pkg::S_DONE;
            end else if (({1'b0, top} + {1'b0, in_data.request_size}) >= {1'b0, cap}) begin
              res_next.status = cra_pkg::ST_REGION_FULL;
              st_next = cra_pkg::S_DONE;
            end else if (fc == '0) begin
              st_next = cra_pkg::S_A_DEC;
            end else begin
              f_addr   = '0;
              idx_next = '0;
              st_next  = cra_pkg::S_A_CHK;
            end
          end else begin
            h_r_next = in_data.handle;
            if (CW'(in_data.handle) < lc) begin
              l_addr  = IW'(in_data.handle);
              st_next = cra_pkg::S_F_RD0;
            end else begin
              st_next = cra_pkg::S_DONE;
            end
          end
        end
      end

      // First-fit scan, one entry a cycle.
      cra_pkg::S_A_CHK: begin
        if (size_r <= f_rdata.size) begin
          found_next = 1'b1;
          cur_next   = f_rdata;
          st_next    = cra_pkg::S_A_DEC;
        end else if (idx + CW'(1) == fc) begin
          st_next = cra_pkg::S_A_DEC;
        end else begin
          f_addr   = IW'(idx + CW'(1));
          idx_next = idx + CW'(1);
        end
      end

      cra_pkg::S_A_DEC: begin
        if (total > (CW+1)'(cra_pkg::TABLE_ENTRIES)) begin
          res_next.status = cra_pkg::ST_TABLE_FULL;
          st_next = cra_pkg::S_DONE;
        end else begin
          l_we    = 1'b1;
          l_addr  = lc[IW-1:0];
          l_wdata = '{off: off, size: used};
          res_next.block_offset = off;
          res_next.new_handle   = cra_pkg::HANDLE_W'(lc);
          lc_next = lc + CW'(1);
          if (!found) begin
            top_next = top + size_r;
            st_next  = cra_pkg::S_DONE;
          end else if (consume) begin
            j_next   = idx;
            ret_next = cra_pkg::S_DONE;
            st_next  = cra_pkg::S_RM_RD;
          end else begin
            f_we    = 1'b1;
            f_addr  = idx[IW-1:0];
            f_wdata = '{off: cur.off + size_r, size: cur.size - size_r};
            st_next = cra_pkg::S_DONE;
          end
        end
      end

      // Remove entry j: shift the tail down by one.
      cra_pkg::S_RM_RD: begin
        if (j + CW'(1) >= fc) begin
          fc_next = fc - CW'(1);
          st_next = ret;
        end else begin
          f_addr  = IW'(j + CW'(1));
          st_next = cra_pkg::S_RM_WR;
        end
      end

      cra_pkg::S_RM_WR: begin
        f_we    = 1'b1;
        f_addr  = j[IW-1:0];
        f_wdata = f_rdata;
        j_next  = j + CW'(1);
        st_next = cra_pkg::S_RM_RD;
      end

      // Insert the freed span at idx: shift the tail up by one.
      cra_pkg::S_INS_RD: begin
        if (j == idx) begin
          f_we    = 1'b1;
          f_addr  = idx[IW-1:0];
          f_wdata = sp;
          fc_next = fc + CW'(1);
          st_next = cra_pkg::S_DONE;
        end else begin
          f_addr  = IW'(j - CW'(1));
          st_next = cra_pkg::S_INS_WR;
        end
      end

      cra_pkg::S_INS_WR: begin
        f_we    = 1'b1;
        f_addr  = j[IW-1:0];
        f_wdata = f_rdata;
        j_next  = j - CW'(1);
        st_next = cra_pkg::S_INS_RD;
      end

      cra_pkg::S_F_RD0: begin
        sp_next = l_rdata;
        l_addr  = last[IW-1:0];
        st_next = cra_pkg::S_F_RD1;
      end

      // Move the last live entry into the freed handle.
      cra_pkg::S_F_RD1: begin
        if (CW'(h_r) < last) begin
          l_we    = 1'b1;
          l_addr  = IW'(h_r);
          l_wdata = l_rdata;
          res_next.entry_moved = 1'b1;
          res_next.moved_from  = cra_pkg::HANDLE_W'(last);
        end
        lc_next  = last;
        idx_next = '0;
        if (fc == '0) begin
          st_next = cra_pkg::S_R_END;
        end else begin
          f_addr  = '0;
          st_next = cra_pkg::S_R_CHK;
        end
      end

      // Walk the free list for the place of the freed span.
      cra_pkg::S_R_CHK: begin
        if (endv < {1'b0, f_rdata.off}) begin
          if (fc == CW'(cra_pkg::TABLE_ENTRIES)) begin
            st_next = cra_pkg::S_DONE;
          end else begin
            j_next  = fc;
            st_next = cra_pkg::S_INS_RD;
          end
        end else if (endv == {1'b0, f_rdata.off}) begin
          if (idx != '0 && p_end == {1'b0, sp.off}) begin
            f_we     = 1'b1;
            f_addr   = IW'(idx - CW'(1));
            f_wdata  = '{off: prev.off, size: ps};
            t_next   = '{off: prev.off, size: ps};
            t_i_next = idx - CW'(1);
            j_next   = idx;
            ret_next = cra_pkg::S_TRIM;
            st_next  = cra_pkg::S_RM_RD;
          end else begin
            f_we     = 1'b1;
            f_addr   = idx[IW-1:0];
            f_wdata  = '{off: sp.off, size: news};
            t_next   = '{off: sp.off, size: news};
            t_i_next = idx;
            st_next  = cra_pkg::S_TRIM;
          end
        end else if ({1'b0, sp.off} == f_end) begin
          t_next   = '{off: f_rdata.off, size: news};
          t_i_next = idx;
          if (idx + CW'(1) < fc) begin
            f_addr  = IW'(idx + CW'(1));
            st_next = cra_pkg::S_R_NXT;
          end else begin
            f_we    = 1'b1;
            f_addr  = idx[IW-1:0];
            f_wdata = '{off: f_rdata.off, size: news};
            st_next = cra_pkg::S_TRIM;
          end
        end else begin
          prev_next = f_rdata;
          if (idx + CW'(1) == fc) begin
            st_next = cra_pkg::S_R_END;
          end else begin
            f_addr   = IW'(idx + CW'(1));
            idx_next = idx + CW'(1);
          end
        end
      end

      // Absorb the following entry when it starts at the span end.
      cra_pkg::S_R_NXT: begin
        f_we   = 1'b1;
        f_addr = idx[IW-1:0];
        if ({1'b0, f_rdata.off} == endv) begin
          f_wdata     = '{off: t.off, size: t.size + f_rdata.size};
          t_next.size = t.size + f_rdata.size;
          j_next      = idx + CW'(1);
          ret_next    = cra_pkg::S_TRIM;
          st_next     = cra_pkg::S_RM_RD;
        end else begin
          f_wdata = t;
          st_next = cra_pkg::S_TRIM;
        end
      end

      cra_pkg::S_R_END: begin
        if (endv < {1'b0, top}) begin
          if (fc == CW'(cra_pkg::TABLE_ENTRIES)) begin
            st_next = cra_pkg::S_DONE;
          end else begin
            idx_next = fc;
            j_next   = fc;
            st_next  = cra_pkg::S_INS_RD;
          end
        end else begin
          top_next = sp.off;
          st_next  = cra_pkg::S_DONE;
        end
      end

      // Lower the top mark when the merged span reaches it.
      cra_pkg::S_TRIM: begin
        if (W'(t.off + t.size) == top) begin
          top_next = top - t.size;
          j_next   = t_i;
          ret_next = cra_pkg::S_DONE;
          st_next  = cra_pkg::S_RM_RD;
        end else begin
          st_next = cra_pkg::S_DONE;
        end
      end

      cra_pkg::S_DONE: begin
        if (slot_free) begin
          st_next = cra_pkg::S_IDLE;
        end
      end

      default: begin
        st_next = cra_pkg::S_IDLE;
      end
    endcase
  end

  `CRA_ASSERT_IMP(a_tables_fit, st == cra_pkg::S_IDLE, ({1'b0, lc} + {1'b0, fc}) <= (CW+1)'(cra_pkg::TABLE_ENTRIES), "live plus free entries exceed table")
  `CRA_ASSERT_NXT(a_done_holds, st == cra_pkg::S_DONE && !slot_free, st == cra_pkg::S_DONE, "result dropped while output slot full")
  `CRA_ASSERT_NXT(a_zero_fast, st == cra_pkg::S_IDLE && in_valid && in_data.func == cra_pkg::FUNC_ALLOC && in_data.request_size == '0, st == cra_pkg::S_DONE && lc == $past(lc) && fc == $past(fc), "zero size request changed state")
  `CRA_ASSERT_IMP(a_scan_bound, st == cra_pkg::S_A_CHK, idx < fc, "first-fit scan past free list end")

endmodule

// File: rtl/coalescing_region_allocator.sv
// Coalescing region allocator: one word in, one word out per request. An allocate
// scans the free list in offset order at one entry a cycle and, when it takes a
// whole free block, shifts the tail down, each entry read and then written; a free
// reads the live table twice, then walks the free list and inserts, merges or
// trims, again shifting entries with a read and a write through the single-port
// free-list RAM. One request is worked at a time; the next word is taken while a
// finished result waits in the output register. No clearing pass follows reset.
module coalescing_region_allocator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cra_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cra_pkg::out_word_t   out_data
);

  logic [cra_pkg::OFF_W-1:0] cap;
  logic                      slot_free;
  logic                      res_valid;
  cra_pkg::out_word_t        res_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(cap) : '0;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= cra_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cap <= pwdata[cra_pkg::OFF_W-1:0];
    end
  end

  assign slot_free = !out_valid || !out_stall;

  // Output register: load a finished word when the slot frees.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      out_data <= res_data;
    end
  end

  cra_engine u_engine (
    .clk(clk),
    .rst(rst),
    .cap(cap),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .res_valid(res_valid),
    .res_data(res_data),
    .slot_free(slot_free)
  );

endmodule

// File: dv/tb.sv
// Self-checking testbench of the coalescing region allocator.
`timescale 1ns / 1ps

module tb;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [2:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_stall;
  cra_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_stall;
  cra_pkg::out_word_t          out_data;

  coalescing_region_allocator uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Predictor state: live table, sorted free list, top mark, capacity.
  logic [cra_pkg::OFF_W-1:0] live_off [cra_pkg::TABLE_ENTRIES];
  logic [cra_pkg::OFF_W-1:0] live_len [cra_pkg::TABLE_ENTRIES];
  logic [cra_pkg::OFF_W-1:0] hole_off [cra_pkg::TABLE_ENTRIES];
  logic [cra_pkg::OFF_W-1:0] hole_len [cra_pkg::TABLE_ENTRIES];
  int unsigned               n_live;
  int unsigned               n_hole;
  logic [cra_pkg::OFF_W-1:0] top_mark;
  logic [cra_pkg::OFF_W-1:0] capacity;

  cra_pkg::out_word_t        pending_results[$];
  int                        errors;
  int                        send_idle_pct;
  int                        recv_idle_pct;
  int                        recv_hold;

  initial begin
    clk = 1'b0;
  end
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void hole_drop(int unsigned i);
    if (i >= n_hole) return;
    for (int unsigned k = i; k + 1 < n_hole; k++) begin
      hole_off[k] = hole_off[k+1];
      hole_len[k] = hole_len[k+1];
    end
    n_hole--;
  endfunction

  function automatic void hole_add(int unsigned i, logic [cra_pkg::OFF_W-1:0] o,
                                   logic [cra_pkg::OFF_W-1:0] s);
    if (n_hole >= cra_pkg::TABLE_ENTRIES || i > n_hole) return;
    for (int unsigned k = n_hole; k > i; k--) begin
      hole_off[k] = hole_off[k-1];
      hole_len[k] = hole_len[k-1];
    end
    hole_off[i] = o;
    hole_len[i] = s;
    n_hole++;
  endfunction

  function automatic void trim_at(int unsigned i);
    if (i < n_hole && cra_pkg::OFF_W'(hole_off[i] + hole_len[i]) == top_mark) begin
      top_mark = top_mark - hole_len[i];
      hole_drop(i);
    end
  endfunction

  // Return a span to the free list, merging neighbors (end compared unwrapped).
  function automatic void give_back(logic [cra_pkg::OFF_W-1:0] st,
                                    logic [cra_pkg::OFF_W-1:0] sz);
    logic [31:0] fin;
    int unsigned i;
    fin = 32'(st) + 32'(sz);
    for (i = 0; i < n_hole; i++) begin
      if (fin < 32'(hole_off[i])) begin
        hole_add(i, st, sz);
        return;
      end
      if (fin == 32'(hole_off[i])) begin
        hole_off[i] = st;
        hole_len[i] = hole_len[i] + sz;
        if (i > 0 && 32'(hole_off[i-1]) + 32'(hole_len[i-1]) == 32'(st)) begin
          hole_len[i-1] = hole_len[i-1] + hole_len[i];
          hole_drop(i);
          i--;
        end
        trim_at(i);
        return;
      end
      if (32'(st) == 32'(hole_off[i]) + 32'(hole_len[i])) begin
        hole_len[i] = hole_len[i] + sz;
        if (i + 1 < n_hole && 32'(hole_off[i+1]) == fin) begin
          hole_len[i] = hole_len[i] + hole_len[i+1];
          hole_drop(i + 1);
        end
        trim_at(i);
        return;
      end
    end
    if (fin < 32'(top_mark)) hole_add(n_hole, st, sz);
    else top_mark = st;
  endfunction

  function automatic cra_pkg::out_word_t predict_alloc(cra_pkg::in_word_t w);
    cra_pkg::out_word_t        r;
    logic [cra_pkg::OFF_W-1:0] sz, used;
    int unsigned               idx, newfc;
    bit                        found, whole;
    r = '0;
    r.status = cra_pkg::ST_OK;
    if (w.func == cra_pkg::FUNC_ALLOC) begin
      sz = w.request_size;
      if (sz == '0) begin
        r.status = cra_pkg::ST_ZERO_SIZE;
      end else if (32'(top_mark) + 32'(sz) >= 32'(capacity)) begin
        r.status = cra_pkg::ST_REGION_FULL;
      end else begin
        found = 0; whole = 0; idx = 0; used = sz; newfc = n_hole;
        for (int unsigned i = 0; i < n_hole; i++) begin
          if (sz <= hole_len[i]) begin
            found = 1; idx = i; break;
          end
        end
        r.block_offset = top_mark;
        if (found) begin
          r.block_offset = hole_off[idx];
          if (32'(sz) + 32'(cra_pkg::MERGE_SLACK) >= 32'(hole_len[idx])) begin
            used = hole_len[idx]; whole = 1; newfc--;
          end
        end
        if (n_live + newfc + 1 > cra_pkg::TABLE_ENTRIES) begin
          r.status = cra_pkg::ST_TABLE_FULL;
          r.block_offset = '0;
        end else begin
          if (!found) top_mark = top_mark + sz;
          else if (whole) hole_drop(idx);
          else begin
            hole_len[idx] = hole_len[idx] - sz;
            hole_off[idx] = hole_off[idx] + sz;
          end
          live_off[n_live] = r.block_offset;
          live_len[n_live] = used;
          r.new_handle = cra_pkg::HANDLE_W'(n_live);
          n_live++;
        end
      end
    end else if (32'(w.handle) < n_live) begin
      logic [cra_pkg::OFF_W-1:0] st, ln;
      int unsigned               last;
      st = live_off[w.handle];
      ln = live_len[w.handle];
      last = n_live - 1;
      if (32'(w.handle) < last) begin
        live_off[w.handle] = live_off[last];
        live_len[w.handle] = live_len[last];
        r.entry_moved = 1'b1;
        r.moved_from = cra_pkg::HANDLE_W'(last);
      end
      n_live = last;
      give_back(st, ln);
    end
    return r;
  endfunction

  // Receiver: random stall, with a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin
    cra_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, out_data.status);
        if (out_data.block_offset !== e.block_offset)
          $display("%0t: block_offset exp %0d got %0d", $time, e.block_offset,
                   out_data.block_offset);
        if (out_data.new_handle !== e.new_handle)
          $display("%0t: new_handle exp %0d got %0d", $time, e.new_handle,
                   out_data.new_handle);
        if (out_data.entry_moved !== e.entry_moved)
          $display("%0t: entry_moved exp %0d got %0d", $time, e.entry_moved,
                   out_data.entry_moved);
        if (out_data.moved_from !== e.moved_from)
          $display("%0t: moved_from exp %0d got %0d", $time, e.moved_from,
                   out_data.moved_from);
        if (out_data !== e) errors++;
      end
    end
  end

  task automatic reg_write(input logic [25:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    capacity = v;
  endtask

  // Offer one word, predict at acceptance, and hold until taken.
  task automatic send_word(input cra_pkg::in_word_t w, input bit check_typed,
                           input cra_pkg::out_word_t typed);
    cra_pkg::out_word_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    p = predict_alloc(w);
    if (check_typed && p !== typed) begin
      $display("%0t: directed row exp %h predictor %h", $time, typed, p);
      errors++;
    end
    pending_results.push_back(p);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (800) @(posedge clk);
  endtask

  function automatic cra_pkg::in_word_t mk(logic f, logic [25:0] s, logic [7:0] h);
    cra_pkg::in_word_t w;
    w.func = f; w.request_size = s; w.handle = h;
    return w;
  endfunction

  function automatic cra_pkg::out_word_t ok_res(cra_pkg::status_t st, logic [25:0] o,
                                                logic [7:0] h);
    cra_pkg::out_word_t r;
    r = '0;
    r.status = st; r.block_offset = o; r.new_handle = h;
    return r;
  endfunction

  // Random word: mostly small allocates and frees of live handles.
  function automatic cra_pkg::in_word_t rand_word();
    int c;
    c = $urandom_range(99);
    if (c < 50)
      return mk(cra_pkg::FUNC_ALLOC, 26'($urandom_range(1, 40000)), 8'($urandom));
    if (c < 54) return mk(cra_pkg::FUNC_ALLOC, 26'($urandom), 8'($urandom));
    if (c < 56) return mk(cra_pkg::FUNC_ALLOC, 26'd0, 8'($urandom));
    if (c < 95 && n_live > 0)
      return mk(cra_pkg::FUNC_FREE, 26'($urandom), 8'($urandom_range(n_live - 1)));
    return mk(cra_pkg::FUNC_FREE, 26'($urandom), 8'($urandom));
  endfunction

  typedef struct {
    cra_pkg::in_word_t  w;
    bit                 typed;
    cra_pkg::out_word_t r;
  } row_t;

  initial begin
    row_t rows[$];
    errors = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 0;
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; in_data = '0;
    capacity = cra_pkg::CAP_RESET;
    n_live = 0; n_hole = 0; top_mark = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed rows against reset capacity.
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd0, 8'hff), 1,
                     ok_res(cra_pkg::ST_ZERO_SIZE, 26'd0, 8'd0)});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'h3ffffff, 8'h00), 1,
                     ok_res(cra_pkg::ST_REGION_FULL, 26'd0, 8'd0)});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'h3ffffff, 8'h00), 1,
                     ok_res(cra_pkg::ST_OK, 26'd0, 8'd0)});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd100, 8'h00), 1,
                     ok_res(cra_pkg::ST_OK, 26'd0, 8'd0)});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd20000, 8'h00), 1,
                     ok_res(cra_pkg::ST_OK, 26'd100, 8'd1)});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd300, 8'h00), 1,
                     ok_res(cra_pkg::ST_OK, 26'd20100, 8'd2)});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd50, 8'h00), 1,
                     ok_res(cra_pkg::ST_OK, 26'd20400, 8'd3)});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'hff), 1,
                     ok_res(cra_pkg::ST_OK, 26'd0, 8'd0)});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'd1), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd1000, 8'h00), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd15000, 8'h00), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'd0), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'd1), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'd0), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'd0), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_FREE, 26'd0, 8'd0), 0, '0});
    rows.push_back('{mk(cra_pkg::FUNC_ALLOC, 26'd20971519, 8'h00), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
    drain();

    // Allocate until refused: the region fills at small capacity, the table at large.
    reg_write(26'd16384);
    for (int i = 0; i < 40; i++)
      send_word(mk(cra_pkg::FUNC_ALLOC, 26'd700, 8'h00), 0, '0);
    drain();
    reg_write(26'h3ffffff);
    for (int i = 0; i < 300; i++)
      send_word(mk(cra_pkg::FUNC_ALLOC, 26'($urandom_range(1, 64)), 8'h00), 0, '0);
    for (int i = 0; i < 60; i++)
      send_word(mk(cra_pkg::FUNC_FREE, 26'd0, 8'($urandom_range(n_live - 1))), 0, '0);
    drain();

    // Random phases with different idling mixes.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 79 : 0;
      recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 19 : 0;
      if (ph == 2) recv_hold = 3000;
      for (int i = 0; i < 160; i++) send_word(rand_word(), 0, '0);
      drain();
      if (ph == 0) reg_write(26'd600000);
      if (ph == 1) reg_write(cra_pkg::CAP_RESET);
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
